// File: rtl/core/range_paint_coverage_counter_top_macros.svh
// Assertion macros shared by the RTL of the coverage counter.
`ifndef RANGE_PAINT_COVERAGE_COUNTER_TOP_MACROS_SVH
`define RANGE_PAINT_COVERAGE_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define RPCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpcc same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define RPCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpcc next-cycle check failed");

`endif

// File: rtl/core/rpcc_pkg.sv
package rpcc_pkg;

  localparam int unsigned ROAD_LENGTH = 65536;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned MAP_WORDS   = (ROAD_LENGTH + WORD_BITS - 1) / WORD_BITS;

  // Field widths of the channels.
  localparam int unsigned POS_W = 17;
  localparam int unsigned TOT_W = 17;

  // Internal widths.
  localparam int unsigned CELL_W = $clog2(ROAD_LENGTH);
  localparam int unsigned BIT_W  = $clog2(WORD_BITS);
  localparam int unsigned ADDR_W = $clog2(MAP_WORDS);
  localparam int unsigned PC_W   = BIT_W + 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CELL_W-1:0]    cell_t;
  typedef logic [PC_W-1:0]      pcnt_t;

  typedef enum logic {
    FUNC_PAINT = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_e;

  typedef enum logic [4:0] {
    ST_WIPE = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_RD   = 5'b00100,
    ST_MOD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  // Number of set bits in one bitmap word, summed as a balanced adder tree.
  function automatic pcnt_t pop_count(input word_t v);
    pcnt_t sums [WORD_BITS];
    for (int i = 0; i < WORD_BITS; i++) begin
      sums[i] = pcnt_t'(v[i]);
    end
    for (int step = 1; step < WORD_BITS; step = step * 2) begin
      for (int i = 0; i + step < WORD_BITS; i = i + 2 * step) begin
        sums[i] = sums[i] + sums[i + step];
      end
    end
    return sums[0];
  endfunction

endpackage

// File: rtl/core/rpcc_if.sv
interface rpcc_in_if;
  import rpcc_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] range_start;
  logic [POS_W-1:0] range_end;
  logic             func;

  modport source (output valid, output range_start, output range_end, output func,
                  input ready);
  modport sink   (input valid, input range_start, input range_end, input func,
                  output ready);
endinterface

interface rpcc_out_if;
  import rpcc_pkg::*;

  logic             valid;
  logic             ready;
  logic [TOT_W-1:0] covered_total;
  logic             range_error;

  modport source (output valid, output covered_total, output range_error, input ready);
  modport sink   (input valid, input covered_total, input range_error, output ready);
endinterface

// File: rtl/core/range_paint_coverage_counter_top.sv
// Range coverage counter for a line of ROAD_LENGTH cells numbered from 1.
// Input channel in_i carries one transaction per range: range_start,
// range_end (inclusive) and func (paint covers the range, clear uncovers it).
// Output channel out_o returns exactly one transaction per input: the number
// of covered cells after the range was applied, and range_error when the
// range was empty, started at zero or ran past the line; such a range
// changes nothing and reports the unchanged count.
// An invalid range goes straight from acceptance to the DONE state. A valid
// range is walked through RD and MOD for each bitmap word it touches, then
// goes to DONE; the single-port bitmap memory is read then written once per
// word. out_o.valid is registered from DONE once the output register is free.
// in_i.ready is high only while no range is being worked on, so a new range
// is taken only after the last one has left DONE for IDLE.
// After reset the bitmap is wiped one word per cycle, all MAP_WORDS = 1024
// words, with in_i.ready low. A stalled receiver holds the result in the
// output register; the next range is still accepted and walked, and it
// waits at the end of its walk until the output register frees up.
module range_paint_coverage_counter_top (
  input  logic clk_i,
  input  logic rst_ni,
  rpcc_in_if.sink    in_i,
  rpcc_out_if.source out_o
);
  import rpcc_pkg::*;

  `include "range_paint_coverage_counter_top_macros.svh"

  // Sequencer state and the item under work.
  state_e             state_q, state_d;
  addr_t              word_q, word_d;
  cell_t              first_q, last_q;
  logic               clear_q, err_q;
  logic [TOT_W-1:0]   count_q, count_d;

  // Output register.
  logic               out_valid_q;
  logic [TOT_W-1:0]   out_total_q;
  logic               out_err_q;

  // Bitmap memory with a registered read port.
  word_t              mem_q [MAP_WORDS];
  word_t              rd_data_q;
  logic               mem_we;
  word_t              mem_wdata;

  logic               in_acc;
  logic               range_bad;
  logic [POS_W-1:0]   start_m1, end_m1;
  logic [BIT_W-1:0]   lo_bit, hi_bit;
  word_t              mask, new_word, flip_bits;
  pcnt_t              flip_cnt;
  logic               out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // A range is rejected if it is empty, starts at cell zero or runs past the line.
  assign range_bad = (in_i.range_start == '0)
                  || (in_i.range_start > in_i.range_end)
                  || (in_i.range_end > POS_W'(ROAD_LENGTH));
  assign start_m1  = in_i.range_start - POS_W'(1);
  assign end_m1    = in_i.range_end - POS_W'(1);

  // Bit mask of the current word: partial at the first and last word only.
  assign lo_bit = (word_q == first_q[CELL_W-1:BIT_W]) ? first_q[BIT_W-1:0] : '0;
  assign hi_bit = (word_q == last_q[CELL_W-1:BIT_W]) ? last_q[BIT_W-1:0] : '1;
  assign mask   = ({WORD_BITS{1'b1}} << lo_bit)
                & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));

  // Only bits that actually change move the count.
  assign new_word  = (clear_q == FUNC_CLEAR) ? (rd_data_q & ~mask) : (rd_data_q | mask);
  assign flip_bits = rd_data_q ^ new_word;
  assign flip_cnt  = pop_count(flip_bits);

  assign mem_we    = (state_q == ST_WIPE) || (state_q == ST_MOD);
  assign mem_wdata = (state_q == ST_MOD) ? new_word : '0;

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    count_d = count_q;
    unique case (state_q)
      ST_WIPE: begin
        word_d = word_q + addr_t'(1);
        if (word_q == addr_t'(MAP_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          word_d  = start_m1[CELL_W-1:BIT_W];
          state_d = range_bad ? ST_DONE : ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_MOD;
      end
      ST_MOD: begin
        if (clear_q == FUNC_CLEAR) begin
          count_d = count_q - TOT_W'(flip_cnt);
        end else begin
          count_d = count_q + TOT_W'(flip_cnt);
        end
        if (word_q == last_q[CELL_W-1:BIT_W]) begin
          state_d = ST_DONE;
        end else begin
          word_d  = word_q + addr_t'(1);
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      word_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      count_q <= count_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      first_q <= start_m1[CELL_W-1:0];
      last_q  <= end_m1[CELL_W-1:0];
      clear_q <= in_i.func;
      err_q   <= range_bad;
    end
    if (state_q == ST_DONE && out_free) begin
      out_total_q <= count_q;
      out_err_q   <= err_q;
    end
  end

  // Bitmap memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[word_q] <= mem_wdata;
    end
    if (state_q == ST_RD) begin
      rd_data_q <= mem_q[word_q];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.covered_total = out_total_q;
  assign out_o.range_error   = out_err_q;

  `RPCC_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= TOT_W'(ROAD_LENGTH))
  `RPCC_ASSERT_NOW(a_walk_bounded, state_q == ST_RD, word_q <= last_q[CELL_W-1:BIT_W])
  `RPCC_ASSERT_NEXT(a_accept_starts, in_acc, state_q == ST_RD || state_q == ST_DONE)
  `RPCC_ASSERT_NOW(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE)

endmodule

// File: tb/coverage_tally_checker.sv
// Watches both channels of the coverage counter. It keeps its own copy of the
// coverage bitmap and the count of covered cells, works out the answer for each
// accepted range, and compares every returned transaction against the oldest
// answer still waiting.
module coverage_tally_checker
  import rpcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rpcc_in_if          range_mon,
  rpcc_out_if         total_mon,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  typedef struct packed {
    logic [TOT_W-1:0] covered_total;
    logic             range_error;
  } tally_t;

  word_t       cover_map [MAP_WORDS];
  int unsigned cells_covered;
  tally_t      expected_tallies [$];
  int unsigned bad_results;

  // Applies one range to the local bitmap and queues the count it leaves behind.
  task automatic predict_range(input logic [POS_W-1:0] first_cell,
                               input logic [POS_W-1:0] last_cell,
                               input func_e            op);
    int unsigned lo_idx, hi_idx, w, lo_bit, hi_bit;
    word_t       span, old_word, new_word, all_ones;
    tally_t      answer;
    all_ones = '1;
    if (first_cell == 0 || first_cell > last_cell || last_cell > ROAD_LENGTH) begin
      answer.covered_total = TOT_W'(cells_covered);
      answer.range_error   = 1'b1;
    end else begin
      lo_idx = first_cell - 1;
      hi_idx = last_cell - 1;
      for (w = lo_idx / WORD_BITS; w <= hi_idx / WORD_BITS; w++) begin
        lo_bit   = (w == lo_idx / WORD_BITS) ? lo_idx % WORD_BITS : 0;
        hi_bit   = (w == hi_idx / WORD_BITS) ? hi_idx % WORD_BITS : WORD_BITS - 1;
        span     = (all_ones << lo_bit) & (all_ones >> (WORD_BITS - 1 - hi_bit));
        old_word = cover_map[w];
        new_word = (op == FUNC_CLEAR) ? (old_word & ~span) : (old_word | span);
        cover_map[w]  = new_word;
        cells_covered = cells_covered + $countones(new_word) - $countones(old_word);
      end
      answer.covered_total = TOT_W'(cells_covered);
      answer.range_error   = 1'b0;
    end
    expected_tallies.push_back(answer);
  endtask

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    if (bad_results < 10) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
    bad_results++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    if (!rst_ni) begin
      cover_map = '{default: '0};
      cells_covered = 0;
      expected_tallies.delete();
      bad_results = 0;
    end else begin
      // The result of a range never leaves in the cycle it is accepted, so the
      // output side is checked before the new answer is queued.
      if (total_mon.valid && total_mon.ready) begin
        if (expected_tallies.size() == 0) begin
          note_mismatch("unexpected result, covered_total", 0, total_mon.covered_total);
        end else begin
          want = expected_tallies.pop_front();
          if (total_mon.covered_total !== want.covered_total) begin
            note_mismatch("covered_total", want.covered_total, total_mon.covered_total);
          end
          if (total_mon.range_error !== want.range_error) begin
            note_mismatch("range_error", want.range_error, total_mon.range_error);
          end
        end
      end
      if (range_mon.valid && range_mon.ready) begin
        predict_range(range_mon.range_start, range_mon.range_end, func_e'(range_mon.func));
      end
    end
    mismatch_count_o <= bad_results;
    pending_count_o  <= expected_tallies.size();
  end

endmodule

// File: tb/tb_range_paint_coverage_counter_top.sv
// Top of the coverage counter testbench. This module only makes stimulus,
// plays the receiver, runs the watchdog and gives the verdict; all prediction
// and comparison lives in the checker instantiated next to the block.
module tb_range_paint_coverage_counter_top;
  import rpcc_pkg::*;

  // Ranges in the random part, on top of the directed ones.
  localparam int unsigned RANDOM_RANGES = 560;
  // The last stretch of random ranges runs with no idling on either side.
  localparam int unsigned QUIET_FROM    = 500;
  // A full-line range walks all 1024 words, each through RD and MOD, and the
  // wipe after reset covers 1024 words as well. A quiet stretch of STALL_LIMIT
  // with no transaction on either channel is far beyond any correct run.
  localparam int unsigned STALL_LIMIT   = 20000;
  // Cycles to keep watching after the last expected result, long enough for
  // the slowest range to surface if the block made up a result of its own.
  localparam int unsigned TAIL_CYCLES   = 2100;

  localparam logic [POS_W-1:0] LAST_CELL = POS_W'(ROAD_LENGTH);

  logic        clk_i;
  logic        rst_ni;
  logic        quiet_tail;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;
  int unsigned pending_count;

  rpcc_in_if  range_ch ();
  rpcc_out_if total_ch ();

  range_paint_coverage_counter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (range_ch),
    .out_o  (total_ch)
  );

  coverage_tally_checker tally_mon (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .range_mon        (range_ch),
    .total_mon        (total_ch),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one range and returns right after the rising edge that accepts it.
  // The valid line is left high so that back-to-back transactions never lower
  // and raise it within the same time step; it only drops for an idle burst.
  task automatic send_range(input logic [POS_W-1:0] first_cell,
                            input logic [POS_W-1:0] last_cell,
                            input func_e            op);
    int unsigned hold;
    @(negedge clk_i);
    if (!quiet_tail && $urandom_range(0, 2) == 0) begin
      hold = $urandom_range(1, 13);
      range_ch.valid <= 1'b0;
      repeat (hold) @(negedge clk_i);
    end
    range_ch.valid       <= 1'b1;
    range_ch.range_start <= first_cell;
    range_ch.range_end   <= last_cell;
    range_ch.func        <= op;
    do @(posedge clk_i); while (!range_ch.ready);
  endtask

  // Draws one random range. Most are valid ranges with random content, and
  // most of those are short, because the block walks every word a range
  // touches. A few span a large part of the line or the whole of it. The rest
  // are noise over all 17 bits and deliberately broken ranges.
  task automatic pick_random_range(output logic [POS_W-1:0] first_cell,
                                   output logic [POS_W-1:0] last_cell,
                                   output func_e            op);
    int unsigned kind, span, lo, hi;
    kind = $urandom_range(0, 99);
    op   = ($urandom_range(0, 9) < 6) ? FUNC_PAINT : FUNC_CLEAR;
    if (kind < 6) begin
      // Noise: any pair of 17-bit values, most of them rejected.
      lo = $urandom_range(0, 131071);
      hi = $urandom_range(0, 131071);
    end else if (kind < 12) begin
      // Broken ranges: zero start, reversed bounds, or an end past the line.
      case ($urandom_range(0, 2))
        0: begin
          lo = 0;
          hi = $urandom_range(0, ROAD_LENGTH);
        end
        1: begin
          hi = $urandom_range(1, ROAD_LENGTH - 1);
          lo = $urandom_range(hi + 1, ROAD_LENGTH);
        end
        default: begin
          lo = $urandom_range(1, ROAD_LENGTH);
          hi = $urandom_range(ROAD_LENGTH + 1, 131071);
        end
      endcase
    end else begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        span = $urandom_range(1, 192);
      end else if (kind < 94) begin
        span = $urandom_range(1, 4096);
      end else begin
        span = $urandom_range(1, ROAD_LENGTH);
      end
      // Some ranges start on a word boundary so both ends of words get hit.
      if ($urandom_range(0, 6) == 0) begin
        lo = WORD_BITS * $urandom_range(0, MAP_WORDS - 1) + 1;
      end else begin
        lo = $urandom_range(1, ROAD_LENGTH);
      end
      hi = lo + span - 1;
      if (hi > ROAD_LENGTH) begin
        hi = ROAD_LENGTH;
      end
    end
    first_cell = POS_W'(lo);
    last_cell  = POS_W'(hi);
  endtask

  // Receiver: ready drops in random bursts, so that stalls land on every phase
  // of a walk, and never drops once the quiet tail begins.
  initial begin : receiver
    int unsigned hold;
    total_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 13);
        total_ch.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end else begin
        total_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles in which no transaction moves on either channel.
  always @(posedge clk_i) begin
    if ((range_ch.valid && range_ch.ready) || (total_ch.valid && total_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [POS_W-1:0] first_cell, last_cell;
    func_e            op;
    quiet_cycles         = 0;
    quiet_tail           = 1'b0;
    range_ch.valid       = 1'b0;
    range_ch.range_start = '0;
    range_ch.range_end   = '0;
    range_ch.func        = FUNC_PAINT;
    rst_ni               = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The block wipes its bitmap after reset with ready low,
    // so the first transaction simply waits for that pass to finish.
    send_range(1, 1, FUNC_PAINT);                    // lowest cell alone
    send_range(LAST_CELL, LAST_CELL, FUNC_PAINT);    // highest cell alone
    send_range(1, LAST_CELL, FUNC_PAINT);            // whole line, count hits 65536
    send_range(100, 200, FUNC_PAINT);                // paint over covered cells
    send_range(64, 65, FUNC_CLEAR);                  // straddles a word boundary
    send_range(1, LAST_CELL, FUNC_CLEAR);            // whole line back to zero
    send_range(5, 9, FUNC_CLEAR);                    // clear over uncovered cells
    send_range(1, 64, FUNC_PAINT);                   // exactly one word
    send_range(65, 128, FUNC_PAINT);                 // the next word
    send_range(32, 96, FUNC_PAINT);                  // overlaps both
    send_range(60, 70, FUNC_CLEAR);
    send_range(0, 10, FUNC_PAINT);                   // zero start is rejected
    send_range(20, 19, FUNC_PAINT);                  // start past end is rejected
    send_range(1, POS_W'(ROAD_LENGTH + 1), FUNC_CLEAR); // end past the line is rejected
    send_range('1, '1, FUNC_CLEAR);                  // all ones in both fields
    send_range(0, 0, FUNC_CLEAR);                    // all zeros in both fields
    send_range(POS_W'(ROAD_LENGTH + 1), '1, FUNC_PAINT); // both bounds past the line
    send_range(POS_W'(ROAD_LENGTH - 63), LAST_CELL, FUNC_PAINT); // last word of the line
    send_range(LAST_CELL, LAST_CELL, FUNC_CLEAR);
    send_range(1000, 40000, FUNC_PAINT);             // many words at once
    send_range(20000, 20000, FUNC_CLEAR);
    send_range(1, POS_W'(ROAD_LENGTH - 1), FUNC_PAINT); // all but the top cell

    // Random part, ending with a stretch where neither side idles.
    for (int unsigned item_idx = 0; item_idx < RANDOM_RANGES; item_idx++) begin
      if (item_idx == QUIET_FROM) begin
        quiet_tail = 1'b1;
      end
      pick_random_range(first_cell, last_cell, op);
      send_range(first_cell, last_cell, op);
    end
    @(negedge clk_i);
    range_ch.valid <= 1'b0;

    // Drain: the watchdog catches a result that never arrives.
    while (pending_count != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rpcc_pkg.sv
rtl/core/rpcc_if.sv
rtl/core/range_paint_coverage_counter_top.sv
tb/coverage_tally_checker.sv
tb/tb_range_paint_coverage_counter_top.sv
